FILE: rtl/mexp_pkg.sv
// mexp_pkg: shared types for the modular exponentiation block
// status codes and controller states; no dependencies
`default_nettype none

package mexp_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_EXP  = 2'd1,
    ST_ZERO_MOD = 2'd2
  } mexp_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT_BASE,
    S_STEP,
    S_WAIT_ACC,
    S_WAIT_SQ,
    S_FINISH
  } mexp_state_e;

endpackage

`default_nettype wire

FILE: rtl/mexp_mulmod.sv
// mexp_mulmod: bit-serial modular multiplier, (a * b) mod m, b scanned from its top bit
// each bit of b takes a modular doubling, then a conditional modular add
// no package dependencies
`default_nettype none

module mexp_mulmod #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] a_i,
  input  wire logic [WIDTH-1:0] b_i,
  input  wire logic [WIDTH-1:0] m_i,
  output logic                  done_o,
  output logic [WIDTH-1:0]      r_o
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] a_q, m_q, b_q, r_q;
  logic [WIDTH-1:0] b_d, r_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // (x + y) mod m for x, y below m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      return d[WIDTH-1:0];
    end
    return s[WIDTH-1:0];
  endfunction

  always_comb begin
    b_d     = b_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      if (!phase_q) begin
        r_d     = add_mod(r_q, r_q, m_q);
        phase_d = 1'b1;
      end else begin
        if (b_q[WIDTH-1]) begin
          r_d = add_mod(r_q, a_q, m_q);
        end
        b_d     = {b_q[WIDTH-2:0], 1'b0};
        phase_d = 1'b0;
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end else if (start_i) begin
      b_d     = b_i;
      r_d     = '0;
      cnt_d   = CW'(WIDTH - 1);
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      a_q <= a_i;
      m_q <= m_i;
    end
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

`default_nettype wire

FILE: rtl/modular_exponentiation_top.sv
// a zero or negative exponent or a zero modulus skips the multiplier and goes straight to
// the result; else the base is reduced mod m, then each exponent bit from the bottom takes
// a modular squaring, preceded by a modular multiply into the accumulator for a one bit
// throughput: one item at a time, set by the single bit-serial modular multiplier; the
// next item is taken the cycle after the result is loaded, even while that result waits
// reset: asynchronous active low, block idle, no result pending; uses mexp_pkg, mexp_mulmod
`default_nettype none

module modular_exponentiation_top #(
  parameter int WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [WIDTH-1:0]        base_i,
  input  wire logic signed [WIDTH-1:0] exponent_i,
  input  wire logic [WIDTH-1:0]        modulus_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [WIDTH-1:0]             power_o,
  output logic [1:0]                   status_o
);

  mexp_pkg::mexp_state_e  state_q, state_d;
  mexp_pkg::mexp_status_e res_st_q, res_st_d, status_q;

  logic [WIDTH-1:0] exp_q, exp_d, mod_q, mod_d, sq_q, sq_d, acc_q, acc_d;
  logic [WIDTH-1:0] one_q, one_d, res_q, res_d, power_q;
  logic             out_valid_q, out_valid_d, load_out;

  logic             mul_start, mul_done;
  logic [WIDTH-1:0] mul_a, mul_b, mul_r;

  mexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .m_i    (mod_d),
    .done_o (mul_done),
    .r_o    (mul_r)
  );

  assign in_ready_o = (state_q == mexp_pkg::S_IDLE);

  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    mod_d     = mod_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    one_d     = one_q;
    res_d     = res_q;
    res_st_d  = res_st_q;
    mul_start = 1'b0;
    mul_a     = acc_q;
    mul_b     = sq_q;
    load_out  = 1'b0;
    case (state_q)
      mexp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          exp_d = exponent_i;
          mod_d = modulus_i;
          one_d = (modulus_i == WIDTH'(1)) ? '0 : WIDTH'(1);
          if (exponent_i == '0) begin
            res_d    = WIDTH'(1);
            res_st_d = mexp_pkg::ST_OK;
            state_d  = mexp_pkg::S_FINISH;
          end else if (exponent_i[WIDTH-1]) begin
            res_d    = '0;
            res_st_d = mexp_pkg::ST_NEG_EXP;
            state_d  = mexp_pkg::S_FINISH;
          end else if (modulus_i == '0) begin
            res_d    = '0;
            res_st_d = mexp_pkg::ST_ZERO_MOD;
            state_d  = mexp_pkg::S_FINISH;
          end else begin
            // base reduction as (1 mod m) * base
            mul_a     = one_d;
            mul_b     = base_i;
            mul_start = 1'b1;
            state_d   = mexp_pkg::S_WAIT_BASE;
          end
        end
      end
      mexp_pkg::S_WAIT_BASE: begin
        if (mul_done) begin
          sq_d    = mul_r;
          acc_d   = one_q;
          state_d = mexp_pkg::S_STEP;
        end
      end
      mexp_pkg::S_STEP: begin
        if (exp_q == '0) begin
          res_d    = acc_q;
          res_st_d = mexp_pkg::ST_OK;
          state_d  = mexp_pkg::S_FINISH;
        end else if (exp_q[0]) begin
          mul_a     = acc_q;
          mul_b     = sq_q;
          mul_start = 1'b1;
          state_d   = mexp_pkg::S_WAIT_ACC;
        end else begin
          mul_a     = sq_q;
          mul_b     = sq_q;
          mul_start = 1'b1;
          state_d   = mexp_pkg::S_WAIT_SQ;
        end
      end
      mexp_pkg::S_WAIT_ACC: begin
        if (mul_done) begin
          acc_d     = mul_r;
          mul_a     = sq_q;
          mul_b     = sq_q;
          mul_start = 1'b1;
          state_d   = mexp_pkg::S_WAIT_SQ;
        end
      end
      mexp_pkg::S_WAIT_SQ: begin
        if (mul_done) begin
          sq_d    = mul_r;
          exp_d   = {1'b0, exp_q[WIDTH-1:1]};
          state_d = mexp_pkg::S_STEP;
        end
      end
      mexp_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = mexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q    <= exp_d;
    mod_q    <= mod_d;
    sq_q     <= sq_d;
    acc_q    <= acc_d;
    one_q    <= one_d;
    res_q    <= res_d;
    res_st_q <= res_st_d;
    if (load_out) begin
      power_q  <= res_q;
      status_q <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign power_o     = power_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

FILE: rtl/mexp_checker.sv
// mexp_checker: port-level assertions for modular_exponentiation_top, bound to it
// depends on mexp_pkg and modular_exponentiation_top
`default_nettype none

module mexp_checker #(
  parameter int WIDTH = 32
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [WIDTH-1:0] power_o,
  input wire logic [1:0]       status_o
);

  // a transaction in keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while previous transaction still in work");

  // error results carry a zero power
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != mexp_pkg::ST_OK) |-> (power_o == '0))
    else $error("error status with non-zero power");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(power_o) && $stable(status_o)))
    else $error("stalled result changed");

  // status never shows the unused code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == mexp_pkg::ST_OK || status_o == mexp_pkg::ST_NEG_EXP ||
                     status_o == mexp_pkg::ST_ZERO_MOD))
    else $error("unused status code");

endmodule

bind modular_exponentiation_top mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .power_o    (power_o),
  .status_o   (status_o)
);

`default_nettype wire
